/* hw/rtl/modem_result_line_classifier_assert.svh */
// Assertion macros shared by the result line classifier RTL.
// Included by the modules that check their own control logic; no other dependencies.
`ifndef MODEM_RESULT_LINE_CLASSIFIER_ASSERT_SVH
`define MODEM_RESULT_LINE_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define MRLC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MRLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MRLC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`define MRLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/mrlc_pkg.sv */
// Package for the modem result line classifier: pattern table, result codes,
// register map and the prefix automaton functions. No dependencies.
`timescale 1ns / 1ps

package mrlc_pkg;

    localparam int NUM_PAT            = 12;
    localparam int MAX_LEN            = 12;
    localparam int PROG_W             = $clog2(MAX_LEN + 1);
    localparam int COUNT_BITS_DEFAULT = 10;
    localparam int LIMIT_W            = 10;
    localparam int LEN_W              = 10;
    localparam int CODE_W             = 4;
    localparam int PADDR_W            = 3;
    localparam int PDATA_W            = 32;

    localparam logic [LIMIT_W-1:0] LINE_LIMIT_RESET = 10'd255;

    // Register index, taken from paddr[2].
    localparam logic REG_LINE_LIMIT = 1'b0;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam logic [CODE_W-1:0] CODE_OK          = 4'd0;
    localparam logic [CODE_W-1:0] CODE_ERROR       = 4'd1;
    localparam logic [CODE_W-1:0] CODE_CONNECT     = 4'd2;
    localparam logic [CODE_W-1:0] CODE_NO_CARRIER  = 4'd3;
    localparam logic [CODE_W-1:0] CODE_NO_DIALTONE = 4'd4;
    localparam logic [CODE_W-1:0] CODE_BUSY        = 4'd5;
    localparam logic [CODE_W-1:0] CODE_DELAYED     = 4'd6;
    localparam logic [CODE_W-1:0] CODE_VOICE       = 4'd7;
    localparam logic [CODE_W-1:0] CODE_FAX         = 4'd8;
    localparam logic [CODE_W-1:0] CODE_NO_ANSWER   = 4'd9;
    localparam logic [CODE_W-1:0] CODE_NO_MATCH    = 4'd10;

    // Patterns in priority order. String literals are right-justified, so the
    // first character of a pattern sits in the highest used byte.
    localparam logic [MAX_LEN*8-1:0] PAT_TEXT [NUM_PAT] = '{
        "ok", "error", "connect", "no carrier", "no dialtone", "no dial tone",
        "busy", "delayed", "voice", "fclass", "fax", "no answer"
    };

    localparam logic [PROG_W-1:0] PAT_LEN [NUM_PAT] = '{
        4'd2, 4'd5, 4'd7, 4'd10, 4'd11, 4'd12, 4'd4, 4'd7, 4'd5, 4'd6, 4'd3, 4'd9
    };

    localparam logic [CODE_W-1:0] PAT_CODE [NUM_PAT] = '{
        CODE_OK, CODE_ERROR, CODE_CONNECT, CODE_NO_CARRIER, CODE_NO_DIALTONE,
        CODE_NO_DIALTONE, CODE_BUSY, CODE_DELAYED, CODE_VOICE, CODE_FAX,
        CODE_FAX, CODE_NO_ANSWER
    };

    typedef struct packed {
        logic       clear;
        logic       feed;
        logic [7:0] ch;
    } mrlc_match_ctl_t;

    function automatic logic [7:0] pat_char(input int p, input int j);
        logic [7:0] c;
        c = '0;
        if (j >= 0 && j < int'(PAT_LEN[p]))
        begin
            c = PAT_TEXT[p][8*(int'(PAT_LEN[p]) - 1 - j) +: 8];
        end
        return c;
    endfunction

    // True when the first k-1 characters equal the k-1 characters that end
    // the matched prefix of length q, so a prefix of length k may follow.
    function automatic logic border_ok(input int p, input int q, input int k);
        logic ok;
        ok = 1'b1;
        for (int j = 0; j < MAX_LEN - 1; j++)
        begin
            if (j < k - 1 && k <= q + 1)
            begin
                if (pat_char(p, j) != pat_char(p, q + 1 - k + j))
                begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    // Longest prefix of pattern p that ends the matched prefix plus ch.
    function automatic logic [PROG_W-1:0] pat_next(input int p, input logic [PROG_W-1:0] q,
                                                   input logic [7:0] ch);
        logic [PROG_W-1:0] res;
        int                qi;
        res = '0;
        qi  = int'(q);
        for (int k = 1; k <= MAX_LEN; k++)
        begin
            if (k <= int'(PAT_LEN[p]) && k <= qi + 1 && pat_char(p, k - 1) == ch
                && border_ok(p, qi, k))
            begin
                res = PROG_W'(k);
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] fold_lower(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            c = b + 8'h20;
        end
        return c;
    endfunction

    // Code of the first found pattern in priority order.
    function automatic logic [CODE_W-1:0] code_of(input logic [NUM_PAT-1:0] found);
        logic [CODE_W-1:0] code;
        code = CODE_NO_MATCH;
        for (int i = NUM_PAT - 1; i >= 0; i--)
        begin
            if (found[i])
            begin
                code = PAT_CODE[i];
            end
        end
        return code;
    endfunction

endpackage

/* hw/rtl/modem_result_line_classifier.sv */
// Result line classifier: accepts modem bytes at up to one per cycle. An accepted byte is
// held in in_byte_reg, and a line-ending byte's result then in the output registers.
// Throughput is one item per cycle, as the line counter and twelve pattern automata update
// together; a line-ending item waits only while an earlier result is stalled. Reset (rst_n,
// asynchronous) sets line_limit to 255 and starts by skipping CR and LF bytes.
// Depends on mrlc_pkg, mrlc_cfg_regs, mrlc_matcher_bank and the assertion header.
`timescale 1ns / 1ps
`include "modem_result_line_classifier_assert.svh"

module modem_result_line_classifier
#(
    parameter int COUNT_BITS = mrlc_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   rx_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mrlc_pkg::CODE_W-1:0]  result_code,
    output logic [mrlc_pkg::LEN_W-1:0]   line_length,
    output logic                         truncated,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrlc_pkg::PADDR_W-1:0] paddr,
    input  logic [mrlc_pkg::PDATA_W-1:0] pwdata,
    output logic [mrlc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int LIM_W = ((COUNT_BITS > mrlc_pkg::LIMIT_W) ? COUNT_BITS
                                                             : mrlc_pkg::LIMIT_W) + 1;

    logic [mrlc_pkg::LIMIT_W-1:0]  line_limit;
    logic [mrlc_pkg::NUM_PAT-1:0]  found;
    mrlc_pkg::mrlc_match_ctl_t     ctl;

    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    logic                          in_line_reg;
    logic                          in_line_next;
    logic [COUNT_BITS-1:0]         cnt_reg;
    logic [COUNT_BITS-1:0]         cnt_next;
    logic                          nul_reg;
    logic                          nul_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [mrlc_pkg::CODE_W-1:0]   code_reg;
    logic [mrlc_pkg::LEN_W-1:0]    len_reg;
    logic                          trunc_reg;

    logic [LIM_W-1:0]              lim_ext;
    logic [LIM_W-1:0]              cap_ext;
    logic [LIM_W-1:0]              lim;
    logic [LIM_W-1:0]              cnt_ext;
    logic                          at_limit;
    logic                          eol;
    logic                          skip;
    logic                          end_line;
    logic                          proc_go;
    logic                          in_accept;

    mrlc_cfg_regs u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .line_limit (line_limit)
    );

    mrlc_matcher_bank u_match
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .found (found)
    );

    // The line bound is the smaller of line_limit and the counter range.
    assign lim_ext  = LIM_W'(line_limit);
    assign cap_ext  = LIM_W'(1) << COUNT_BITS;
    assign lim      = (lim_ext < cap_ext) ? lim_ext : cap_ext;
    assign cnt_ext  = LIM_W'(cnt_reg);
    assign at_limit = (cnt_ext + LIM_W'(1)) >= lim;

    assign eol      = (in_byte_reg == mrlc_pkg::CHAR_CR) || (in_byte_reg == mrlc_pkg::CHAR_LF);
    assign skip     = !in_line_reg && eol;
    assign end_line = !skip && (eol || at_limit);

    // An item that ends a line needs a free output register; others never wait.
    assign proc_go   = in_valid_reg && (!end_line || !out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !proc_go;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_line_next = in_line_reg;
        cnt_next     = cnt_reg;
        nul_next     = nul_reg;
        ctl.clear    = proc_go && end_line;
        ctl.feed     = proc_go && !skip && !end_line && !nul_reg
                       && (in_byte_reg != mrlc_pkg::CHAR_NUL);
        ctl.ch       = mrlc_pkg::fold_lower(in_byte_reg);
        if (proc_go && !skip)
        begin
            if (end_line)
            begin
                in_line_next = 1'b0;
                cnt_next     = '0;
                nul_next     = 1'b0;
            end
            else
            begin
                in_line_next = 1'b1;
                cnt_next     = cnt_reg + COUNT_BITS'(1);
                nul_next     = nul_reg || (in_byte_reg == mrlc_pkg::CHAR_NUL);
            end
        end
    end

    assign out_valid_next = ctl.clear || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_line_reg   <= 1'b0;
            cnt_reg       <= '0;
            nul_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_line_reg   <= in_line_next;
            cnt_reg       <= cnt_next;
            nul_reg       <= nul_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_go)
            begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= rx_byte;
        end
        if (ctl.clear)
        begin
            code_reg  <= mrlc_pkg::code_of(found);
            len_reg   <= cnt_ext[mrlc_pkg::LEN_W-1:0];
            trunc_reg <= !eol;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_code = code_reg;
    assign line_length = len_reg;
    assign truncated   = trunc_reg;

    `MRLC_ASSERT_NEXT(a_end_clears_line, clk, rst_n, proc_go && end_line,
        (cnt_reg == '0) && !in_line_reg && !nul_reg, "line state not cleared after a result")
    `MRLC_ASSERT_IMPLIES(a_result_from_end, clk, rst_n, $rose(out_valid_reg),
        $past(proc_go && end_line), "result raised without a line end")
    `MRLC_ASSERT_NEXT(a_char_opens_line, clk, rst_n, proc_go && !skip && !end_line,
        in_line_reg, "kept character did not open a line")

endmodule

/* hw/rtl/mrlc_cfg_regs.sv */
// APB register file of the result line classifier: holds line_limit.
// Depends on mrlc_pkg for the register map and reset value.
`timescale 1ns / 1ps

module mrlc_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrlc_pkg::PADDR_W-1:0] paddr,
    input  logic [mrlc_pkg::PDATA_W-1:0] pwdata,
    output logic [mrlc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic [mrlc_pkg::LIMIT_W-1:0] line_limit
);

    logic [mrlc_pkg::LIMIT_W-1:0] limit_reg;
    logic [mrlc_pkg::LIMIT_W-1:0] limit_next;
    logic                         hit;

    assign hit    = (paddr[2] == mrlc_pkg::REG_LINE_LIMIT);
    assign pready = 1'b1;

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && hit)
        begin
            limit_next = pwdata[mrlc_pkg::LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= mrlc_pkg::LINE_LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata = {{(mrlc_pkg::PDATA_W - mrlc_pkg::LIMIT_W){1'b0}}, limit_reg};
        end
    end

    assign line_limit = limit_reg;

endmodule

/* hw/rtl/mrlc_matcher_bank.sv */
// Twelve prefix automata, one per response pattern, with their found mask.
// Depends on mrlc_pkg and the shared assertion header.
`timescale 1ns / 1ps
`include "modem_result_line_classifier_assert.svh"

module mrlc_matcher_bank
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrlc_pkg::mrlc_match_ctl_t     ctl,
    output logic [mrlc_pkg::NUM_PAT-1:0]  found
);

    logic [mrlc_pkg::PROG_W-1:0] prog_reg  [mrlc_pkg::NUM_PAT];
    logic [mrlc_pkg::PROG_W-1:0] prog_next [mrlc_pkg::NUM_PAT];
    logic [mrlc_pkg::NUM_PAT-1:0] found_reg;
    logic [mrlc_pkg::NUM_PAT-1:0] found_next;

    // All automata step in the same cycle; a found pattern stops stepping.
    always_comb
    begin
        found_next = found_reg;
        for (int i = 0; i < mrlc_pkg::NUM_PAT; i++)
        begin
            prog_next[i] = prog_reg[i];
            if (ctl.clear)
            begin
                prog_next[i]  = '0;
                found_next[i] = 1'b0;
            end
            else if (ctl.feed && !found_reg[i])
            begin
                prog_next[i] = mrlc_pkg::pat_next(i, prog_reg[i], ctl.ch);
                if (prog_next[i] == mrlc_pkg::PAT_LEN[i])
                begin
                    found_next[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= '0;
            for (int i = 0; i < mrlc_pkg::NUM_PAT; i++)
            begin
                prog_reg[i] <= '0;
            end
        end
        else
        begin
            found_reg <= found_next;
            for (int i = 0; i < mrlc_pkg::NUM_PAT; i++)
            begin
                prog_reg[i] <= prog_next[i];
            end
        end
    end

    assign found = found_reg;

    `MRLC_ASSERT_NEXT(a_found_sticky, clk, rst_n, !ctl.clear, (found_reg & $past(found_reg)) == $past(found_reg), "found pattern lost without a clear")
    `MRLC_ASSERT_NEXT(a_clear_found, clk, rst_n, ctl.clear, found_reg == '0, "found mask not cleared at end of line")

endmodule
